// ----- hw/rtl/mll_pkg.sv -----
`default_nettype none

package mll_pkg;

    localparam int NAME_MAX   = 15;
    localparam int BIN_DIGITS = 15;
    localparam int NUM_WORDS  = 18;

    // Token kinds, carried on the result channel's tuser.
    localparam logic [2:0] KIND_ERROR   = 3'd0;
    localparam logic [2:0] KIND_IDENT   = 3'd1;
    localparam logic [2:0] KIND_NUMBER  = 3'd2;
    localparam logic [2:0] KIND_WORD    = 3'd3;
    localparam logic [2:0] KIND_COMMENT = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] line;
        logic [14:0] num;
        logic [4:0]  widx;
        logic [3:0]  len;
        logic [63:0] name_lo;
        logic [55:0] name_hi;
        logic        last;
    } mll_item_t;

    // Up to two result items produced by one text byte; valid[1] implies valid[0].
    typedef struct packed {
        logic [1:0] valid;
        mll_item_t  item1;
        mll_item_t  item0;
    } mll_push_t;

    // Reserved words, alphabetical, first character in the low byte.
    localparam logic [63:0] WORD_TEXT [NUM_WORDS] = '{
        64'h0000_0000_0064_6e61,   // and
        64'h0000_006e_6967_6562,   // begin
        64'h006e_6165_6c6f_6f62,   // boolean
        64'h0000_0000_6669_6c65,   // elif
        64'h0000_0000_0064_6e65,   // end
        64'h0000_0065_736c_6166,   // false
        64'h0000_0000_0072_6f66,   // for
        64'h0000_0000_0000_6669,   // if
        64'h0072_6567_6574_6e69,   // integer
        64'h0000_0000_0074_6f6e,   // not
        64'h0000_0000_0000_666f,   // of
        64'h0000_0000_0000_726f,   // or
        64'h006d_6172_676f_7270,   // program
        64'h0000_0000_6461_6572,   // read
        64'h0000_0000_0074_6573,   // set
        64'h0000_0000_0000_6f74,   // to
        64'h0000_0000_6575_7274,   // true
        64'h0000_0065_7469_7277    // write
    };

    localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
        4'd3, 4'd5, 4'd7, 4'd4, 4'd3, 4'd5, 4'd3, 4'd2, 4'd7,
        4'd3, 4'd2, 4'd2, 4'd7, 4'd4, 4'd3, 4'd2, 4'd4, 4'd5
    };

    // Compare a zero-padded name against every reserved word at once.
    // Returns {hit, index}.
    function automatic logic [5:0] word_lookup(input logic [63:0] name_lo,
                                               input logic [3:0]  len);
        logic       hit;
        logic [4:0] idx;
        hit = 1'b0;
        idx = '0;
        for (int w = 0; w < NUM_WORDS; w++) begin
            if (len == WORD_LEN[w] && name_lo == WORD_TEXT[w]) begin
                hit = 1'b1;
                idx = 5'(w);
            end
        end
        return {hit, idx};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mini_language_lexer.sv -----
`default_nettype none

// Streaming lexer for a small language. Feed one text byte per beat on the
// s_axis side; a zero byte ends the text, reports an end-of-text token and
// returns the lexer to its reset state for the next text. Tokens come out on
// m_axis, one per beat: identifiers, reserved words (index into the
// alphabetical table of 18), binary numbers written 0b..., comments in
// brace-dash or hash form, errors, and end of text. A token is reported on
// the beat of the byte that ends it, and that byte is then scanned again, so
// one input beat yields zero, one or two output beats; tlast marks the final
// output beat of each input byte. Each byte is handled in the cycle it is
// accepted: the scanner state is updated and the results are written into a
// four-entry output queue, from which m_axis is driven directly, so a byte's
// results are registered in the queue before they are offered on m_axis. The
// input takes one byte every cycle while the queue holds two entries or fewer,
// so the sustained rate is one byte per cycle whenever the consumer keeps up;
// bytes that close a token and then raise an error or end the text, and bytes
// that raise an error at the end of the text, need two output beats and are
// limited by the single result port. After an error, bytes are dropped (lines
// not counted) until the zero byte.

module mini_language_lexer
    import mll_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // text_byte

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [159:0]      m_axis_tdata,   // line_number, number_value, word_index,
                                              // name_length, name_low, name_high
    output logic [2:0]        m_axis_tuser,   // token_kind
    output logic              m_axis_tlast    // last result of this input byte
);

    logic      accept;
    mll_push_t push;
    mll_item_t head;
    logic      room;

    // Take a byte only when the queue can absorb both results it may cause.
    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mll_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .text_byte (s_axis_tdata),
        .push      (push)
    );

    mll_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .room       (room),
        .head_valid (m_axis_tvalid),
        .head_ready (m_axis_tready),
        .head       (head)
    );

    // Pack the result fields, first field in the low bits.
    assign m_axis_tdata = {head.name_hi, head.name_lo, head.len,
                           head.widx, head.num, head.line};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

// ----- hw/rtl/mll_scan.sv -----
`default_nettype none

module mll_scan
    import mll_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] text_byte,
    output mll_push_t       push
);

    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_IDENT = 3'd1;
    localparam logic [2:0] M_ZERO  = 3'd2;
    localparam logic [2:0] M_BIN   = 3'd3;
    localparam logic [2:0] M_BRACE = 3'd4;
    localparam logic [2:0] M_BCOM  = 3'd5;
    localparam logic [2:0] M_HCOM  = 3'd6;
    localparam logic [2:0] M_DROP  = 3'd7;

    logic [2:0]  mode_reg,  mode_next;
    logic [15:0] line_reg,  line_next;
    logic [3:0]  count_reg, count_next;
    logic [14:0] bin_reg,   bin_next;
    logic [3:0]  dc_reg,    dc_next;
    logic        dash_reg,  dash_next;
    logic [7:0]  name_reg [NAME_MAX];

    logic        store_we;
    logic [3:0]  store_wa;

    logic        is_lower, is_upper, is_digit, is_ws, is_bin;
    logic [15:0] line_inc;

    // Idle decode of the current byte
    logic        idle_emit, idle_nl, idle_start, idle_end;
    logic [2:0]  idle_kind, idle_mode;

    logic        run_idle, idle_second, clear;
    logic        v0, v1;
    logic [2:0]  k0, k1;

    logic [63:0] name_lo;
    logic [55:0] name_hi;
    logic [5:0]  lookup;

    assign is_lower = text_byte >= 8'h61 && text_byte <= 8'h7a;
    assign is_upper = text_byte >= 8'h41 && text_byte <= 8'h5a;
    assign is_digit = text_byte >= 8'h30 && text_byte <= 8'h39;
    assign is_bin   = text_byte == 8'h30 || text_byte == 8'h31;
    assign is_ws    = text_byte == 8'h20 || text_byte == 8'h09 || text_byte == 8'h0d;
    assign line_inc = (line_reg != 16'hffff) ? line_reg + 16'd1 : line_reg;

    always_comb begin
        idle_emit  = 1'b0;
        idle_kind  = KIND_ERROR;
        idle_mode  = M_IDLE;
        idle_nl    = 1'b0;
        idle_start = 1'b0;
        idle_end   = 1'b0;
        priority if (is_ws) begin
            idle_mode = M_IDLE;
        end else if (text_byte == 8'h0a) begin
            idle_nl = 1'b1;
        end else if (is_lower) begin
            idle_start = 1'b1;
            idle_mode  = M_IDENT;
        end else if (text_byte == 8'h30) begin
            idle_mode = M_ZERO;
        end else if (text_byte == 8'h7b) begin
            idle_mode = M_BRACE;
        end else if (text_byte == 8'h23) begin
            idle_mode = M_HCOM;
        end else if (text_byte == 8'h00) begin
            idle_emit = 1'b1;
            idle_kind = KIND_END;
            idle_end  = 1'b1;
        end else begin
            idle_emit = 1'b1;
            idle_kind = KIND_ERROR;
            idle_mode = M_DROP;
        end
    end

    // Name bytes past the current length read as zero.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            name_lo[8*i +: 8] = (4'(i) < count_reg) ? name_reg[i] : 8'h00;
        end
        for (int i = 0; i < NAME_MAX - 8; i++) begin
            name_hi[8*i +: 8] = (4'(i + 8) < count_reg) ? name_reg[i + 8] : 8'h00;
        end
    end

    assign lookup = word_lookup(name_lo, count_reg);

    always_comb begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        count_next  = count_reg;
        bin_next    = bin_reg;
        dc_next     = dc_reg;
        dash_next   = dash_reg;
        store_we    = 1'b0;
        store_wa    = count_reg;
        run_idle    = 1'b0;
        idle_second = 1'b0;
        clear       = 1'b0;
        v0          = 1'b0;
        v1          = 1'b0;
        k0          = KIND_ERROR;
        k1          = KIND_ERROR;

        if (accept) begin
            unique case (mode_reg)
                M_IDLE: begin
                    run_idle = 1'b1;
                end
                M_IDENT: begin
                    if (is_lower || is_digit || text_byte == 8'h5f) begin
                        if (count_reg >= 4'(NAME_MAX)) begin
                            v0        = 1'b1;
                            mode_next = M_DROP;
                        end else begin
                            store_we   = 1'b1;
                            count_next = count_reg + 4'd1;
                        end
                    end else if (is_upper) begin
                        v0        = 1'b1;
                        mode_next = M_DROP;
                    end else begin
                        v0          = 1'b1;
                        k0          = lookup[5] ? KIND_WORD : KIND_IDENT;
                        count_next  = '0;
                        mode_next   = M_IDLE;
                        run_idle    = 1'b1;
                        idle_second = 1'b1;
                    end
                end
                M_ZERO, M_BRACE: begin
                    if (mode_reg == M_ZERO && text_byte == 8'h62) begin
                        bin_next  = '0;
                        dc_next   = '0;
                        mode_next = M_BIN;
                    end else if (mode_reg == M_BRACE && text_byte == 8'h2d) begin
                        dash_next = 1'b0;
                        mode_next = M_BCOM;
                    end else begin
                        v0        = 1'b1;
                        mode_next = M_DROP;
                        if (text_byte == 8'h00) begin
                            v1    = 1'b1;
                            k1    = KIND_END;
                            clear = 1'b1;
                        end
                    end
                end
                M_BIN: begin
                    if (is_bin) begin
                        if (dc_reg >= 4'(BIN_DIGITS)) begin
                            v0        = 1'b1;
                            mode_next = M_DROP;
                        end else begin
                            bin_next = {bin_reg[13:0], text_byte[0]};
                            dc_next  = dc_reg + 4'd1;
                        end
                    end else begin
                        v0          = 1'b1;
                        k0          = KIND_NUMBER;
                        bin_next    = '0;
                        dc_next     = '0;
                        mode_next   = M_IDLE;
                        run_idle    = 1'b1;
                        idle_second = 1'b1;
                    end
                end
                M_BCOM: begin
                    if (text_byte == 8'h00) begin
                        v0    = 1'b1;
                        k0    = KIND_COMMENT;
                        v1    = 1'b1;
                        k1    = KIND_END;
                        clear = 1'b1;
                    end else if (dash_reg && text_byte == 8'h7d) begin
                        v0        = 1'b1;
                        k0        = KIND_COMMENT;
                        dash_next = 1'b0;
                        mode_next = M_IDLE;
                    end else begin
                        if (text_byte == 8'h0a) begin
                            line_next = line_inc;
                        end
                        dash_next = text_byte == 8'h2d;
                    end
                end
                M_HCOM: begin
                    if (text_byte == 8'h0a || text_byte == 8'h00) begin
                        v0          = 1'b1;
                        k0          = KIND_COMMENT;
                        mode_next   = M_IDLE;
                        run_idle    = 1'b1;
                        idle_second = 1'b1;
                    end
                end
                M_DROP: begin
                    if (text_byte == 8'h00) begin
                        v0    = 1'b1;
                        k0    = KIND_END;
                        clear = 1'b1;
                    end
                end
                default: begin
                    mode_next = M_DROP;
                end
            endcase

            // Rescan the terminating byte as a fresh start character.
            if (run_idle) begin
                if (idle_emit) begin
                    if (idle_second) begin
                        v1 = 1'b1;
                        k1 = idle_kind;
                    end else begin
                        v0 = 1'b1;
                        k0 = idle_kind;
                    end
                end
                if (idle_nl) begin
                    line_next = line_inc;
                end
                if (idle_start) begin
                    store_we   = 1'b1;
                    store_wa   = '0;
                    count_next = 4'd1;
                end
                mode_next = idle_mode;
                if (idle_end) begin
                    clear = 1'b1;
                end
            end

            if (clear) begin
                mode_next  = M_IDLE;
                line_next  = 16'd1;
                count_next = '0;
                bin_next   = '0;
                dc_next    = '0;
                dash_next  = 1'b0;
            end
        end
    end

    // Every result of a byte reports the state as it stood before the byte.
    always_comb begin
        push.valid         = {v1, v0};
        push.item0.kind    = k0;
        push.item0.line    = line_reg;
        push.item0.num     = (k0 == KIND_NUMBER) ? bin_reg : '0;
        push.item0.widx    = (k0 == KIND_WORD) ? lookup[4:0] : '0;
        push.item0.len     = (k0 == KIND_WORD || k0 == KIND_IDENT) ? count_reg : '0;
        push.item0.name_lo = (k0 == KIND_WORD || k0 == KIND_IDENT) ? name_lo : '0;
        push.item0.name_hi = (k0 == KIND_WORD || k0 == KIND_IDENT) ? name_hi : '0;
        push.item0.last    = !v1;
        push.item1.kind    = k1;
        push.item1.line    = line_reg;
        push.item1.num     = '0;
        push.item1.widx    = '0;
        push.item1.len     = '0;
        push.item1.name_lo = '0;
        push.item1.name_hi = '0;
        push.item1.last    = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            line_reg  <= 16'd1;
            count_reg <= '0;
            bin_reg   <= '0;
            dc_reg    <= '0;
            dash_reg  <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            count_reg <= count_next;
            bin_reg   <= bin_next;
            dc_reg    <= dc_next;
            dash_reg  <= dash_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            name_reg[store_wa] <= text_byte;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mll_outq.sv -----
`default_nettype none

module mll_outq
    import mll_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  mll_push_t push,
    output logic      room,
    output logic      head_valid,
    input  wire logic head_ready,
    output mll_item_t head
);

    mll_item_t  mem [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [2:0] n_push;

    assign head_valid = cnt_reg != 3'd0;
    assign head       = mem[rd_reg];
    assign room       = cnt_reg <= 3'd2;
    assign pop        = head_valid && head_ready;
    assign n_push     = 3'(push.valid[0]) + 3'(push.valid[1]);

    always_comb begin
        wr_next  = wr_reg + n_push[1:0];
        rd_next  = pop ? rd_reg + 2'd1 : rd_reg;
        cnt_next = cnt_reg + n_push - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid[0]) begin
            mem[wr_reg] <= push.item0;
        end
        if (push.valid[1]) begin
            mem[wr_reg + 2'd1] <= push.item1;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mll_checker.sv -----
`default_nettype none

module mll_checker
    import mll_pkg::*;
(
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [159:0] m_axis_tdata,
    input wire logic [2:0]   m_axis_tuser,
    input wire logic         m_axis_tlast
);

    // Output is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result beat valid right after reset");

    // Hold a stalled result beat.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result beat changed");

    // Only names carry a length and name bytes.
    a_name_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != KIND_IDENT && m_axis_tuser != KIND_WORD
            |-> m_axis_tdata[159:36] == '0)
        else $error("name bytes on a non-name token");

    // Only numbers carry a value, and the line count is never zero.
    a_number_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[15:0] != 16'd0
            && (m_axis_tuser == KIND_NUMBER || m_axis_tdata[30:16] == 15'd0))
        else $error("bad line number or stray number value");

    // Byte after reset is accepted only when the queue has room: tready must
    // not stay low while nothing is waiting at the output.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid && $past(!m_axis_tvalid) && $past(aresetn) |-> s_axis_tready)
        else $error("input stalled with an empty output queue");

endmodule

bind mini_language_lexer mll_checker u_mll_checker (.*);

`default_nettype wire

// ----- bench/tb.sv -----
import mll_pkg::*;

typedef enum logic [3:0] {
    SCAN_IDLE,
    SCAN_NAME,
    SCAN_ZERO,
    SCAN_BIN,
    SCAN_BRACE,
    SCAN_BLOCK,
    SCAN_HASH,
    SCAN_DROP
} scan_state_e;

localparam int RESERVED_COUNT = 18;
localparam int NAME_LIMIT     = 15;
localparam int DIGIT_LIMIT    = 15;

function automatic string reserved_word(input int unsigned idx);
    case (idx)
        0:  return "and";
        1:  return "begin";
        2:  return "boolean";
        3:  return "elif";
        4:  return "end";
        5:  return "false";
        6:  return "for";
        7:  return "if";
        8:  return "integer";
        9:  return "not";
        10: return "of";
        11: return "or";
        12: return "program";
        13: return "read";
        14: return "set";
        15: return "to";
        16: return "true";
        default: return "write";
    endcase
endfunction

// Tracks the lexer state, turns accepted text bytes into expected tokens and
// compares emitted tokens against them in order.
class token_checker;
    scan_state_e mode;
    logic [15:0] line_no;
    logic [7:0]  name_chars [NAME_LIMIT];
    int unsigned name_len;
    logic [14:0] bin_value;
    int unsigned bin_digits;
    bit          dash_seen;

    mll_item_t   byte_tokens[$];
    mll_item_t   pending_tokens[$];
    int unsigned mismatches;
    int unsigned byte_count;

    function new();
        mismatches = 0;
        byte_count = 0;
        restart();
    endfunction

    function void restart();
        mode       = SCAN_IDLE;
        line_no    = 16'd1;
        name_len   = 0;
        bin_value  = '0;
        bin_digits = 0;
        dash_seen  = 1'b0;
        foreach (name_chars[i]) name_chars[i] = 8'h00;
    endfunction

    function void bump_line();
        if (line_no != 16'hFFFF) line_no++;
    endfunction

    function void push_token(logic [2:0] kind, logic [14:0] num, logic [4:0] widx,
                             bit named);
        mll_item_t t;
        t      = '0;
        t.kind = kind;
        t.line = line_no;
        t.num  = num;
        t.widx = widx;
        if (named) begin
            t.len = 4'(name_len);
            for (int i = 0; i < name_len; i++) begin
                if (i < 8) t.name_lo[8*i +: 8] = name_chars[i];
                else       t.name_hi[8*(i-8) +: 8] = name_chars[i];
            end
        end
        byte_tokens.push_back(t);
    endfunction

    function void fail();
        push_token(KIND_ERROR, '0, '0, 1'b0);
        mode = SCAN_DROP;
    endfunction

    function void end_text();
        push_token(KIND_END, '0, '0, 1'b0);
        restart();
    endfunction

    function int find_word();
        string w;
        bit    same;
        for (int i = 0; i < RESERVED_COUNT; i++) begin
            w    = reserved_word(i);
            same = (w.len() == name_len);
            for (int k = 0; same && k < name_len; k++)
                if (w[k] != name_chars[k]) same = 1'b0;
            if (same) return i;
        end
        return -1;
    endfunction

    function void idle_char(logic [7:0] b);
        if (b == " " || b == "\t" || b == "\r") begin
            // whitespace between tokens: nothing to do
        end else if (b == "\n") begin
            bump_line();
        end else if (b >= "a" && b <= "z") begin
            name_chars[0] = b;
            name_len      = 1;
            mode          = SCAN_NAME;
        end else if (b == "0") begin
            mode = SCAN_ZERO;
        end else if (b == "{") begin
            mode = SCAN_BRACE;
        end else if (b == "#") begin
            mode = SCAN_HASH;
        end else if (b == 8'h00) begin
            end_text();
        end else begin
            fail();
        end
    endfunction

    function void scan_byte(logic [7:0] b);
        int w;
        byte_tokens.delete();
        byte_count++;
        case (mode)
            SCAN_IDLE: idle_char(b);
            SCAN_NAME: begin
                if ((b >= "a" && b <= "z") || (b >= "0" && b <= "9") || b == "_") begin
                    if (name_len >= NAME_LIMIT) fail();
                    else name_chars[name_len++] = b;
                end else if (b >= "A" && b <= "Z") begin
                    fail();
                end else begin
                    w = find_word();
                    if (w >= 0) push_token(KIND_WORD, '0, 5'(w), 1'b1);
                    else        push_token(KIND_IDENT, '0, '0, 1'b1);
                    name_len = 0;
                    mode     = SCAN_IDLE;
                    idle_char(b);
                end
            end
            SCAN_ZERO, SCAN_BRACE: begin
                if (mode == SCAN_ZERO && b == "b") begin
                    bin_value  = '0;
                    bin_digits = 0;
                    mode       = SCAN_BIN;
                end else if (mode == SCAN_BRACE && b == "-") begin
                    dash_seen = 1'b0;
                    mode      = SCAN_BLOCK;
                end else begin
                    fail();
                    if (b == 8'h00) end_text();
                end
            end
            SCAN_BIN: begin
                if (b == "0" || b == "1") begin
                    if (bin_digits >= DIGIT_LIMIT) begin
                        fail();
                    end else begin
                        bin_value = {bin_value[13:0], b[0]};
                        bin_digits++;
                    end
                end else begin
                    push_token(KIND_NUMBER, bin_value, '0, 1'b0);
                    bin_value  = '0;
                    bin_digits = 0;
                    mode       = SCAN_IDLE;
                    idle_char(b);
                end
            end
            SCAN_BLOCK: begin
                if (b == 8'h00) begin
                    push_token(KIND_COMMENT, '0, '0, 1'b0);
                    end_text();
                end else if (dash_seen && b == "}") begin
                    push_token(KIND_COMMENT, '0, '0, 1'b0);
                    dash_seen = 1'b0;
                    mode      = SCAN_IDLE;
                end else begin
                    if (b == "\n") bump_line();
                    dash_seen = (b == "-");
                end
            end
            SCAN_HASH: begin
                if (b == "\n" || b == 8'h00) begin
                    push_token(KIND_COMMENT, '0, '0, 1'b0);
                    mode = SCAN_IDLE;
                    idle_char(b);
                end
            end
            default: begin
                mode = SCAN_DROP;
                if (b == 8'h00) end_text();
            end
        endcase
        if (byte_tokens.size() != 0) byte_tokens[byte_tokens.size()-1].last = 1'b1;
        foreach (byte_tokens[i]) pending_tokens.push_back(byte_tokens[i]);
    endfunction

    function void report(string why, mll_item_t want, mll_item_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("token mismatch (%s) at %0t", why, $realtime);
            $display("  expected kind=%0d line=%0d num=%0d widx=%0d len=%0d lo=%h hi=%h last=%b",
                     want.kind, want.line, want.num, want.widx, want.len,
                     want.name_lo, want.name_hi, want.last);
            $display("  actual   kind=%0d line=%0d num=%0d widx=%0d len=%0d lo=%h hi=%h last=%b",
                     got.kind, got.line, got.num, got.widx, got.len,
                     got.name_lo, got.name_hi, got.last);
        end
    endfunction

    function void check_token(mll_item_t got);
        mll_item_t want;
        bit        bad;
        if (pending_tokens.size() == 0) begin
            report("no token expected", '0, got);
            return;
        end
        want = pending_tokens.pop_front();
        bad  = (got.kind !== want.kind) || (got.line !== want.line) ||
               (got.num !== want.num) || (got.widx !== want.widx) ||
               (got.len !== want.len) || (got.name_lo !== want.name_lo) ||
               (got.name_hi !== want.name_hi) || (got.last !== want.last);
        if (bad) report("field differs", want, got);
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Run length: stop the random part once this many bytes have been accepted.
    localparam int unsigned ITEM_TARGET  = 1950;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 16;

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [7:0]     s_axis_tdata;     // text_byte
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [159:0]   m_axis_tdata;     // line_number, number_value, word_index,
                                      // name_length, name_low, name_high
    logic [2:0]     m_axis_tuser;     // token_kind
    logic           m_axis_tlast;     // last token of this text byte

    token_checker   tokens;
    mll_item_t      seen;
    logic [7:0]     text_buf[$];
    bit             hold_request = 1'b0;
    int unsigned    cycle_count  = 0;

    mini_language_lexer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 aclk = ~aclk;

    // Bound the run; a hung handshake ends here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Sample both channels at the rising edge. Inputs move on the falling edge,
    // so the values seen here are the ones the design sampled too. Feed the
    // byte into the predictor before checking the token of the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) tokens.scan_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                seen.kind    = m_axis_tuser;
                seen.line    = m_axis_tdata[15:0];
                seen.num     = m_axis_tdata[30:16];
                seen.widx    = m_axis_tdata[35:31];
                seen.len     = m_axis_tdata[39:36];
                seen.name_lo = m_axis_tdata[103:40];
                seen.name_hi = m_axis_tdata[159:104];
                seen.last    = m_axis_tlast;
                tokens.check_token(seen);
            end
        end
    end

    // Token sink: switch between stall styles at random intervals. Once
    // the random part starts, hold tready low for a long stretch so the output
    // queue fills and the lexer backs up its input.
    initial begin : token_sink
        int unsigned style;
        int unsigned style_left;
        int unsigned phase;
        bit          hold_done;
        m_axis_tready = 1'b0;
        style      = 0;
        style_left = 0;
        phase      = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (style_left == 0) begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(32, 256);
            end
            style_left--;
            phase++;
            case (style)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((phase % 5) < 2);
            endcase
        end
    end

    function automatic void push_str(input string s);
        for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
    endfunction

    function automatic logic [7:0] name_char();
        int unsigned r;
        r = $urandom_range(0, 37);
        if (r < 26) return 8'("a" + r);
        if (r < 36) return 8'("0" + r - 26);
        return "_";
    endfunction

    // Whitespace between tokens; leave it out now and then so tokens touch.
    function automatic void add_spacing();
        int unsigned n;
        if ($urandom_range(0, 3) == 0) return;
        n = $urandom_range(1, 3);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       text_buf.push_back(" ");
                1:       text_buf.push_back("\t");
                2:       text_buf.push_back("\r");
                default: text_buf.push_back("\n");
            endcase
        end
    endfunction

    // Mostly legal names; a few at the length limit, over it, or running
    // into an uppercase letter.
    function automatic void add_name();
        int unsigned len;
        int unsigned r;
        if ($urandom_range(0, 2) == 0) begin
            push_str(reserved_word($urandom_range(0, RESERVED_COUNT - 1)));
        end else begin
            r = $urandom_range(0, 19);
            if (r < 2)       len = NAME_LIMIT;
            else if (r == 2) len = $urandom_range(NAME_LIMIT + 1, NAME_LIMIT + 3);
            else             len = $urandom_range(1, NAME_LIMIT - 1);
            text_buf.push_back(8'("a" + $urandom_range(0, 25)));
            repeat (len - 1) text_buf.push_back(name_char());
        end
        if ($urandom_range(0, 15) == 0) text_buf.push_back(8'("A" + $urandom_range(0, 25)));
    endfunction

    // Binary literal: empty, ordinary, full width, or one or two digits too many.
    function automatic void add_number();
        int unsigned digits;
        int unsigned r;
        push_str("0b");
        r = $urandom_range(0, 19);
        if (r == 0)     digits = $urandom_range(DIGIT_LIMIT + 1, DIGIT_LIMIT + 2);
        else if (r < 4) digits = DIGIT_LIMIT;
        else            digits = $urandom_range(0, DIGIT_LIMIT);
        repeat (digits) text_buf.push_back(8'("0" + $urandom_range(0, 1)));
    endfunction

    // Brace-dash comment with arbitrary body bytes. Keep a close brace out of
    // the body except right after the opener, where it must not close.
    function automatic void add_block_comment(input bit closed);
        int unsigned n;
        int unsigned r;
        logic [7:0]  c;
        push_str("{-");
        n = $urandom_range(0, 10);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 19);
            if (r < 5)                  c = "-";
            else if (r < 8)             c = "\n";
            else if (r < 10 && k == 0)  c = "}";
            else begin
                do c = 8'($urandom_range(1, 255)); while (c == "}");
            end
            text_buf.push_back(c);
        end
        if (closed) push_str("-}");
    endfunction

    function automatic void add_hash_comment();
        int unsigned n;
        logic [7:0]  c;
        text_buf.push_back("#");
        n = $urandom_range(0, 8);
        repeat (n) begin
            do c = 8'($urandom_range(1, 255)); while (c == "\n");
            text_buf.push_back(c);
        end
        text_buf.push_back("\n");
    endfunction

    // One short text: a few tokens, an occasional stray byte, and an ending
    // that sometimes leaves a token open at the zero byte.
    function automatic void build_text();
        int unsigned count;
        int unsigned pick;
        count = $urandom_range(1, 7);
        repeat (count) begin
            add_spacing();
            pick = $urandom_range(0, 99);
            if (pick < 40)      add_name();
            else if (pick < 65) add_number();
            else if (pick < 78) add_block_comment(1'b1);
            else if (pick < 90) add_hash_comment();
            else if (pick < 96) push_str("\n\n");
            else                text_buf.push_back(8'($urandom_range(1, 255)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 10)      add_block_comment(1'b0);
        else if (pick < 13) text_buf.push_back("{");
        else if (pick < 16) text_buf.push_back("0");
        else if (pick < 19) text_buf.push_back("#");
        else if (pick < 30) add_name();
        else if (pick < 40) add_number();
        else                add_spacing();
        text_buf.push_back(8'h00);
    endfunction

    // Offer the buffered bytes in bursts of random length with random gaps.
    // Valid stays high across back-to-back bytes; it drops only in a gap.
    task automatic send_text(input bit no_gaps);
        int unsigned burst_left;
        int unsigned gap;
        burst_left = 0;
        for (int i = 0; i < text_buf.size(); i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if (!no_gaps && $urandom_range(0, 3) != 0) begin
                    gap = $urandom_range(1, 8);
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            burst_left--;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= text_buf[i];
            @(posedge aclk);
            while (!s_axis_tready) @(posedge aclk);
            @(negedge aclk);
        end
        text_buf.delete();
    endtask

    initial begin : stimulus
        tokens        = new();
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed text: reserved word, empty number, comment whose opener dash
        // must not close it, name running into uppercase, a dropped high byte,
        // then bad starts and open tokens cut off by the zero byte.
        push_str("if 0b\n{-}-}x5_Q");
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h00);
        text_buf.push_back("{");
        text_buf.push_back(8'h00);
        push_str("{-a");
        text_buf.push_back(8'h00);
        text_buf.push_back("0");
        text_buf.push_back(8'h00);
        text_buf.push_back("@");
        text_buf.push_back(8'h00);
        send_text(1'b0);

        // Random texts; the sink's long hold starts along with them.
        hold_request = 1'b1;
        while (tokens.byte_count < ITEM_TARGET) begin
            build_text();
            send_text(1'b0);
        end

        s_axis_tvalid <= 1'b0;
        while (tokens.pending_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tokens.mismatches == 0 && tokens.pending_tokens.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
